// ===== rtl/ille_pkg.sv =====
package ille_pkg;

    localparam int CAPACITY_DEF   = 256;
    localparam int VALUE_BITS_DEF = 32;

    localparam int OPCODE_W = 3;
    localparam int POS_W    = 9;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 9;

    localparam logic [OPCODE_W-1:0] OP_GET      = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_INS_HEAD = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_INS_TAIL = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_INS_POS  = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_DEL_POS  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_POS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

    localparam logic signed [DATA_W-1:0] READ_INVALID = -32'sd1;

    typedef struct packed {
        logic [OPCODE_W-1:0]      opcode;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] item_value;
    } t_req;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic [STATUS_W-1:0]      status;
        logic [LEN_W-1:0]         length;
    } t_res;

    // request class after position and pool checks
    typedef enum logic [2:0] {
        K_BAD,
        K_FULL,
        K_GET,
        K_HEAD,
        K_TAIL,
        K_MID,
        K_DEL0,
        K_DELN
    } t_kind;

    typedef struct packed {
        logic load_req;
        logic start;
        logic walk;
        logic fetch;
        logic link_wr;
        logic commit;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  walk_done;
        logic  out_free;
    } t_sts;

endpackage

// ===== rtl/ille_ctrl.sv =====
module ille_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  ille_pkg::t_sts   i_sts,
    output ille_pkg::t_cmd   o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_CHECK  = 6'b000010,
        S_WALK   = 6'b000100,
        S_FETCH  = 6'b001000,
        S_LINK   = 6'b010000,
        S_COMMIT = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.kind inside {ille_pkg::K_GET, ille_pkg::K_MID,
                                       ille_pkg::K_DEL0, ille_pkg::K_DELN}) begin
                    n_state = S_WALK;
                end else begin
                    n_state = S_COMMIT;
                end
            end
            S_WALK: begin
                if (i_sts.walk_done) begin
                    if (i_sts.kind == ille_pkg::K_DELN) begin
                        n_state = S_FETCH;
                    end else if (i_sts.kind == ille_pkg::K_MID) begin
                        n_state = S_LINK;
                    end else begin
                        n_state = S_COMMIT;
                    end
                end
            end
            S_FETCH: begin
                n_state = S_COMMIT;
            end
            S_LINK: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_cmd.load_req = (r_state == S_IDLE) && i_valid;
    assign o_cmd.start    = (r_state == S_CHECK);
    assign o_cmd.walk     = (r_state == S_WALK);
    assign o_cmd.fetch    = (r_state == S_FETCH);
    assign o_cmd.link_wr  = (r_state == S_LINK);
    assign o_cmd.commit   = (r_state == S_COMMIT) && i_sts.out_free;

`ifndef NO_ASSERTIONS
    a_accept_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_valid) |=> (r_state == S_CHECK))
        else $error("accepted request did not move to check");
`endif

endmodule

// ===== rtl/ille_dp.sv =====
module ille_dp #(
    parameter int CAPACITY   = ille_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = ille_pkg::VALUE_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ille_pkg::t_req   i_req,
    input  ille_pkg::t_cmd   i_cmd,
    output ille_pkg::t_sts   o_sts,
    output logic             o_valid,
    input  logic             i_ready,
    output ille_pkg::t_res   o_res
);

    localparam int SW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > ille_pkg::POS_W) ? CW : ille_pkg::POS_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    // node and free pool storage
    logic [VALUE_BITS-1:0] r_val_mem  [CAPACITY];
    logic [SW-1:0]         r_link_mem [CAPACITY];
    logic [SW-1:0]         r_pool_mem [CAPACITY];

    logic [VALUE_BITS-1:0] r_val_rd;
    logic [SW-1:0]         r_link_rd;
    logic [SW-1:0]         r_pool_rd;
    logic [SW-1:0]         r_pool_addr;
    logic                  r_pool_fresh;

    ille_pkg::t_req r_req;
    ille_pkg::t_res r_res;
    logic           r_out_valid;

    logic [SW-1:0] r_head, r_tail, r_cur, r_victim;
    logic [CW-1:0] r_count, r_free, r_low, r_left;
    logic          r_first;

    logic [SW-1:0] n_head, n_tail;
    logic [CW-1:0] n_count, n_free, n_low;

    ille_pkg::t_kind kind;
    ille_pkg::t_res  res;
    logic [PW-1:0]   pos_x, cnt_x;
    logic            free_zero, is_last, is_del;
    logic [CW-1:0]   walk_init, pool_top;
    logic [SW-1:0]   cur_slot, new_slot, victim;

    logic                  link_we;
    logic [SW-1:0]         link_waddr, link_wdata, link_raddr;
    logic                  val_we;
    logic signed [63:0]    val_wide, rd_wide;
    logic [VALUE_BITS-1:0] val_store;
    logic                  pool_we;
    logic [31:0]           len_wide;

    assign pos_x     = PW'(r_req.position);
    assign cnt_x     = PW'(r_count);
    assign free_zero = (r_free == '0);
    assign is_last   = (pos_x == cnt_x - PW'(1));
    assign pool_top  = r_free - CW'(1);
    assign cur_slot  = r_first ? r_head : r_link_rd;
    assign new_slot  = r_pool_fresh ? r_pool_addr : r_pool_rd;
    assign is_del    = (kind == ille_pkg::K_DEL0) || (kind == ille_pkg::K_DELN);
    assign victim    = (kind == ille_pkg::K_DEL0) ? r_cur : r_victim;
    assign val_wide  = 64'(r_req.item_value);
    assign val_store = val_wide[VALUE_BITS-1:0];
    assign rd_wide   = 64'(signed'(r_val_rd));

    always_comb begin
        kind = ille_pkg::K_BAD;
        case (r_req.opcode)
            ille_pkg::OP_GET: begin
                kind = (pos_x < cnt_x) ? ille_pkg::K_GET : ille_pkg::K_BAD;
            end
            ille_pkg::OP_INS_HEAD: begin
                kind = free_zero ? ille_pkg::K_FULL : ille_pkg::K_HEAD;
            end
            ille_pkg::OP_INS_TAIL: begin
                kind = free_zero ? ille_pkg::K_FULL : ille_pkg::K_TAIL;
            end
            ille_pkg::OP_INS_POS: begin
                if (pos_x > cnt_x) begin
                    kind = ille_pkg::K_BAD;
                end else if (free_zero) begin
                    kind = ille_pkg::K_FULL;
                end else if (pos_x == '0) begin
                    kind = ille_pkg::K_HEAD;
                end else if (pos_x == cnt_x) begin
                    kind = ille_pkg::K_TAIL;
                end else begin
                    kind = ille_pkg::K_MID;
                end
            end
            ille_pkg::OP_DEL_POS: begin
                if (pos_x >= cnt_x) begin
                    kind = ille_pkg::K_BAD;
                end else if (pos_x == '0) begin
                    kind = ille_pkg::K_DEL0;
                end else begin
                    kind = ille_pkg::K_DELN;
                end
            end
            default: begin
                kind = ille_pkg::K_BAD;
            end
        endcase
    end

    always_comb begin
        case (kind)
            ille_pkg::K_GET:                  walk_init = CW'(pos_x);
            ille_pkg::K_MID, ille_pkg::K_DELN: walk_init = CW'(pos_x - PW'(1));
            default:                          walk_init = '0;
        endcase
    end

    // link memory write select
    always_comb begin
        link_we    = 1'b0;
        link_waddr = new_slot;
        link_wdata = r_link_rd;
        if (i_cmd.link_wr) begin
            link_we = 1'b1;
        end else if (i_cmd.commit) begin
            case (kind)
                ille_pkg::K_HEAD: begin
                    link_we    = 1'b1;
                    link_wdata = r_head;
                end
                ille_pkg::K_TAIL: begin
                    link_we    = (r_count != '0);
                    link_waddr = r_tail;
                    link_wdata = new_slot;
                end
                ille_pkg::K_MID: begin
                    link_we    = 1'b1;
                    link_waddr = r_cur;
                    link_wdata = new_slot;
                end
                ille_pkg::K_DELN: begin
                    link_we    = 1'b1;
                    link_waddr = r_cur;
                end
                default: begin
                    link_we = 1'b0;
                end
            endcase
        end
    end

    assign link_raddr = i_cmd.walk ? cur_slot : r_link_rd;
    assign val_we     = i_cmd.commit && ((kind == ille_pkg::K_HEAD) ||
                        (kind == ille_pkg::K_TAIL) || (kind == ille_pkg::K_MID));
    assign pool_we    = i_cmd.commit && is_del && (r_free < CAP_C);

    always_ff @(posedge i_clk) begin
        if (link_we) begin
            r_link_mem[link_waddr] <= link_wdata;
        end
        if (i_cmd.walk || i_cmd.fetch) begin
            r_link_rd <= r_link_mem[link_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (val_we) begin
            r_val_mem[new_slot] <= val_store;
        end
        if (i_cmd.walk) begin
            r_val_rd <= r_val_mem[cur_slot];
        end
    end

    // pool entries below the low-water mark were never written; the slot index itself stands in for them
    always_ff @(posedge i_clk) begin
        if (pool_we) begin
            r_pool_mem[r_free[SW-1:0]] <= victim;
        end
        if (i_cmd.start) begin
            r_pool_rd    <= r_pool_mem[pool_top[SW-1:0]];
            r_pool_addr  <= pool_top[SW-1:0];
            r_pool_fresh <= (pool_top < r_low);
        end
    end

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        n_free  = r_free;
        n_low   = r_low;
        case (kind)
            ille_pkg::K_HEAD, ille_pkg::K_TAIL, ille_pkg::K_MID: begin
                n_count = r_count + CW'(1);
                n_free  = pool_top;
                n_low   = (pool_top < r_low) ? pool_top : r_low;
                if (kind == ille_pkg::K_HEAD) begin
                    n_head = new_slot;
                    if (r_count == '0) begin
                        n_tail = new_slot;
                    end
                end else if (kind == ille_pkg::K_TAIL) begin
                    n_tail = new_slot;
                    if (r_count == '0) begin
                        n_head = new_slot;
                    end
                end
            end
            ille_pkg::K_DEL0, ille_pkg::K_DELN: begin
                n_count = r_count - CW'(1);
                if (r_free < CAP_C) begin
                    n_free = r_free + CW'(1);
                end
                if (kind == ille_pkg::K_DEL0) begin
                    n_head = r_link_rd;
                end else if (is_last) begin
                    n_tail = r_cur;
                end
                if (n_count == '0) begin
                    n_head = '0;
                    n_tail = '0;
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_comb begin
        len_wide       = 32'(n_count);
        res.length     = len_wide[ille_pkg::LEN_W-1:0];
        res.read_value = '0;
        res.status     = ille_pkg::ST_DONE;
        case (kind)
            ille_pkg::K_GET: begin
                res.read_value = rd_wide[ille_pkg::DATA_W-1:0];
            end
            ille_pkg::K_BAD: begin
                res.status = ille_pkg::ST_BAD_POS;
                if (r_req.opcode == ille_pkg::OP_GET) begin
                    res.read_value = ille_pkg::READ_INVALID;
                end
            end
            ille_pkg::K_FULL: begin
                res.status = ille_pkg::ST_FULL;
            end
            default: begin
                res.status = ille_pkg::ST_DONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req <= i_req;
        end
        if (i_cmd.start) begin
            r_left  <= walk_init;
            r_first <= 1'b1;
        end else if (i_cmd.walk) begin
            r_first <= 1'b0;
            r_cur   <= cur_slot;
            if (r_left != '0) begin
                r_left <= r_left - CW'(1);
            end
        end
        if (i_cmd.fetch) begin
            r_victim <= r_link_rd;
        end
        if (i_cmd.commit) begin
            r_res <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_free      <= CAP_C;
            r_low       <= CAP_C;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_count <= n_count;
                r_free  <= n_free;
                r_low   <= n_low;
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.kind      = kind;
    assign o_sts.walk_done = (r_left == '0);
    assign o_sts.out_free  = !r_out_valid || i_ready;
    assign o_valid         = r_out_valid;
    assign o_res           = r_res;

`ifndef NO_ASSERTIONS
    a_slots_conserved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_count} + {1'b0, r_free}) == (CW + 1)'(CAPACITY))
        else $error("entry count and free count do not add up to capacity");

    a_low_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_low <= r_free)
        else $error("pool low-water mark above free count");

    a_empty_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_head == '0 && r_tail == '0))
        else $error("empty list with nonzero head or tail");
`endif

endmodule

// ===== rtl/indexed_linked_list_engine.sv =====
// Indexed singly linked list engine.
// Request channel: i_valid / o_ready with payload i_req (opcode, position,
// item_value). Result channel: o_valid / i_ready with payload o_res
// (read_value, status, length). Every request gives exactly one result.
// One request is handled at a time; o_ready is high only when the engine is idle.
// Inserts at head or tail (an insert before position 0 or before the length is
// one of these) and refused requests go from the check step straight to commit;
// a get or a delete at position k walks the list first, and so does an insert
// before a position k inside the list, which then writes a link; a delete
// past position 0 fetches the victim's link after the walk. The walk follows one
// next link per cycle through the link memory.
// The result sits in an output register; while the receiver holds i_ready
// low the engine finishes the next request up to its last step and waits
// there, and the held result stays unchanged.
// Reset (i_rst_n low, synchronous) empties the list and refills the free
// pool at once; no clearing pass is needed and requests are taken in the
// first cycle after reset.
module indexed_linked_list_engine #(
    parameter int CAPACITY   = ille_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = ille_pkg::VALUE_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  ille_pkg::t_req   i_req,
    output logic             o_valid,
    input  logic             i_ready,
    output ille_pkg::t_res   o_res
);

    ille_pkg::t_cmd cmd;
    ille_pkg::t_sts sts;

    ille_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    ille_dp #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (o_res)
    );

endmodule

// ===== verif/testbench.sv =====
module testbench;
    import ille_pkg::*;

    localparam int LIST_CAP    = CAPACITY_DEF;
    localparam int TOTAL_OPS   = 1450;
    localparam int FILL_OPS    = 330;
    localparam int HOLD_CYCLES = 3000;
    localparam int DRAIN_WAIT  = LIST_CAP + 50;
    localparam int CYCLE_LIMIT = 2000000;

    typedef enum {GROW, SHRINK, MIXED} list_mode_e;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    t_req i_req   = '0;
    logic o_ready;
    logic o_valid;
    t_res o_res;

    t_req                     pending_ops[$];
    t_res                     replies_due[$];
    logic signed [DATA_W-1:0] list_vals[$];

    int mismatch_count = 0;
    int replies_seen   = 0;
    int cyc            = 0;
    int burst_left     = 0;
    int gap_left       = 0;
    int hold_left      = 0;
    bit hold_done      = 1'b0;
    int stall_mode     = 0;
    int stall_left     = 0;

    indexed_linked_list_engine dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (o_res)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // list model: values in list order, slot bookkeeping is invisible at the ports
    function automatic t_res apply_list_op(t_req rq);
        t_res r;
        int   len;
        int   pos;
        r.read_value = '0;
        r.status     = ST_DONE;
        len = list_vals.size();
        pos = rq.position;
        case (rq.opcode)
            OP_GET: begin
                if (pos < len) begin
                    r.read_value = list_vals[pos];
                end else begin
                    r.read_value = READ_INVALID;
                    r.status     = ST_BAD_POS;
                end
            end
            OP_INS_HEAD, OP_INS_TAIL: begin
                if (len == LIST_CAP) begin
                    r.status = ST_FULL;
                end else if (rq.opcode == OP_INS_HEAD) begin
                    list_vals.push_front(rq.item_value);
                end else begin
                    list_vals.push_back(rq.item_value);
                end
            end
            OP_INS_POS: begin
                if (pos > len) begin
                    r.status = ST_BAD_POS;
                end else if (len == LIST_CAP) begin
                    r.status = ST_FULL;
                end else begin
                    list_vals.insert(pos, rq.item_value);
                end
            end
            OP_DEL_POS: begin
                if (pos >= len) begin
                    r.status = ST_BAD_POS;
                end else begin
                    list_vals.delete(pos);
                end
            end
            default: begin
                r.status = ST_BAD_POS;
            end
        endcase
        r.length = LEN_W'(list_vals.size());
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 19);
        case (r)
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return -32'sd1;
            3: return 32'sd0;
            default: return $urandom;
        endcase
    endfunction

    // length is a hint only: requests still queued are not yet applied
    function automatic t_req make_list_req(list_mode_e mode);
        t_req rq;
        int   len;
        int   r;
        int   p;
        int   top;
        int   c_head;
        int   c_tail;
        int   c_pos;
        int   c_get;
        len = list_vals.size();
        case (mode)
            GROW: begin
                c_head = 30; c_tail = 55; c_pos = 85; c_get = 92;
            end
            SHRINK: begin
                c_head = 8; c_tail = 16; c_pos = 26; c_get = 42;
            end
            default: begin
                c_head = 20; c_tail = 40; c_pos = 60; c_get = 80;
            end
        endcase
        r = $urandom_range(0, 99);
        if (r < c_head) begin
            rq.opcode = OP_INS_HEAD;
        end else if (r < c_tail) begin
            rq.opcode = OP_INS_TAIL;
        end else if (r < c_pos) begin
            rq.opcode = OP_INS_POS;
        end else if (r < c_get) begin
            rq.opcode = OP_GET;
        end else if (r < 98) begin
            rq.opcode = OP_DEL_POS;
        end else begin
            rq.opcode = OPCODE_W'(OP_DEL_POS + $urandom_range(1, 3));
        end
        top = (rq.opcode == OP_INS_POS) ? len : len - 1;
        if (top < 0) begin
            top = 0;
        end
        p = $urandom_range(0, 99);
        if (p < 8) begin
            rq.position = '0;
        end else if (p < 16) begin
            rq.position = POS_W'(len);
        end else if (p < 22) begin
            rq.position = POS_W'($urandom_range(0, (1 << POS_W) - 1));
        end else begin
            rq.position = POS_W'($urandom_range(0, top));
        end
        rq.item_value = pick_value();
        return rq;
    endfunction

    task automatic add_req(logic [OPCODE_W-1:0] op, int pos, logic signed [DATA_W-1:0] val);
        t_req rq;
        rq.opcode     = op;
        rq.position   = POS_W'(pos);
        rq.item_value = val;
        pending_ops.push_back(rq);
    endtask

    task automatic check_reply(t_res got);
        t_res want;
        if (replies_due.size() == 0) begin
            $display("%0t: unexpected result: expected none, got %p", $time, got);
            mismatch_count++;
        end else begin
            want = replies_due.pop_front();
            if (got.read_value !== want.read_value) begin
                $display("%0t: read_value: expected %0d, got %0d",
                         $time, want.read_value, got.read_value);
                mismatch_count++;
            end
            if (got.status !== want.status) begin
                $display("%0t: status: expected %0d, got %0d", $time, want.status, got.status);
                mismatch_count++;
            end
            if (got.length !== want.length) begin
                $display("%0t: length: expected %0d, got %0d", $time, want.length, got.length);
                mismatch_count++;
            end
        end
    endtask

    // request driver: bursts with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid    <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else begin
            if (i_valid && o_ready) begin
                replies_due.push_back(apply_list_op(i_req));
            end
            if (!i_valid || o_ready) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    i_valid  <= 1'b0;
                end else if (pending_ops.size() != 0) begin
                    i_req   <= pending_ops.pop_front();
                    i_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result receiver: stall patterns plus one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else if (!hold_done && replies_seen >= 500) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            i_ready   <= 1'b0;
        end else begin
            if (stall_left == 0) begin
                stall_mode <= $urandom_range(0, 2);
                stall_left <= $urandom_range(50, 400);
            end else begin
                stall_left <= stall_left - 1;
            end
            case (stall_mode)
                0: i_ready <= 1'b1;
                1: i_ready <= ($urandom_range(0, 3) != 0);
                default: i_ready <= ((cyc % 7) > 2);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            check_reply(o_res);
            replies_seen <= replies_seen + 1;
        end
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc == CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        int         total;
        int         seg;
        list_mode_e mode;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty list corner cases
        add_req(OP_GET, 0, 32'sd0);
        add_req(OP_DEL_POS, 0, 32'sd0);
        add_req(OP_INS_POS, 1, 32'sd7);
        // build [min, max, 0x12345678, -1, 0]
        add_req(OP_INS_POS, 0, 32'sh7fff_ffff);
        add_req(OP_INS_HEAD, 0, 32'sh8000_0000);
        add_req(OP_INS_TAIL, 511, -32'sd1);
        add_req(OP_INS_POS, 3, 32'sd0);
        add_req(OP_INS_POS, 2, 32'sh1234_5678);
        for (int k = 0; k < 5; k++) begin
            add_req(OP_GET, k, 32'sd0);
        end
        add_req(OP_GET, 5, 32'sd0);
        add_req(OP_GET, 511, 32'sd0);
        for (int k = 1; k <= 3; k++) begin
            add_req(OPCODE_W'(OP_DEL_POS + k), 511, -32'sd1);
        end
        // delete at tail, then append must follow the new tail
        add_req(OP_DEL_POS, 4, 32'sd0);
        add_req(OP_INS_TAIL, 0, 32'sd5);
        add_req(OP_GET, 4, 32'sd0);
        add_req(OP_DEL_POS, 2, 32'sd0);
        add_req(OP_DEL_POS, 0, 32'sd0);
        add_req(OP_DEL_POS, 2, 32'sd0);
        add_req(OP_DEL_POS, 0, 32'sd0);
        add_req(OP_DEL_POS, 0, 32'sd0);
        // list emptied: head and tail restart
        add_req(OP_INS_TAIL, 0, 32'sd9);
        add_req(OP_GET, 0, 32'sd0);
        total = pending_ops.size();

        // fill to capacity and push against it
        for (int k = 0; k < FILL_OPS; k++) begin
            while (pending_ops.size() >= 2) @(posedge i_clk);
            pending_ops.push_back(make_list_req(GROW));
            total++;
        end
        while (total < TOTAL_OPS) begin
            mode = list_mode_e'($urandom_range(0, 2));
            seg  = $urandom_range(60, 250);
            for (int k = 0; k < seg && total < TOTAL_OPS; k++) begin
                while (pending_ops.size() >= 2) @(posedge i_clk);
                pending_ops.push_back(make_list_req(mode));
                total++;
            end
        end

        while (pending_ops.size() != 0 || i_valid || replies_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ille_pkg.sv
rtl/ille_ctrl.sv
rtl/ille_dp.sv
rtl/indexed_linked_list_engine.sv
verif/testbench.sv
